// ===== hw/rtl/mips_subset_execute_unit_assert.svh =====
// Assertion macros for the execute unit.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSEU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSEU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mseu_pkg.sv =====
package mseu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;
    localparam int XLEN      = 32;

    localparam logic [5:0] OP_SPECIAL  = 6'b000000;
    localparam logic [5:0] OP_SPECIAL2 = 6'b011100;
    localparam logic [5:0] OP_BEQ      = 6'b000100;
    localparam logic [5:0] OP_BNE      = 6'b000101;
    localparam logic [5:0] OP_ADDI     = 6'b001000;
    localparam logic [5:0] OP_SLTI     = 6'b001010;
    localparam logic [5:0] OP_ANDI     = 6'b001100;
    localparam logic [5:0] OP_ORI      = 6'b001101;
    localparam logic [5:0] OP_LUI      = 6'b001111;

    localparam logic [5:0] FN_ADD     = 6'b100000;
    localparam logic [5:0] FN_SUB     = 6'b100010;
    localparam logic [5:0] FN_AND     = 6'b100100;
    localparam logic [5:0] FN_OR      = 6'b100101;
    localparam logic [5:0] FN_SLT     = 6'b101010;
    localparam logic [5:0] FN_SYSCALL = 6'b001100;
    localparam logic [5:0] FN_MUL     = 6'b000010;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd4;

    localparam logic [XLEN-1:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [XLEN-1:0] SYS_EXIT       = 32'd10;
    localparam logic [XLEN-1:0] SYS_PRINT_CHAR = 32'd11;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_INSTR   = 2'd1,
        FAULT_SYSCALL = 2'd2
    } fault_t;

    typedef struct packed {
        logic              branch_taken;
        logic [15:0]       branch_offset;
        logic              print_valid;
        logic              print_kind;
        logic [XLEN-1:0]   print_value;
        logic              halt;
        fault_t            fault;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } reg_write_t;

endpackage

// ===== hw/rtl/mseu_ram.sv =====
module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hw/rtl/mips_subset_execute_unit.sv =====
// Channel | Dir | Ports                          | Content
// s_      | in  | s_tvalid s_tready s_tdata[31:0] | instr_word
// m_      | out | m_tvalid m_tready m_tdata[55:0] | branch, print, halt, fault
//         |     | m_tuser[0]                     | print_kind
// One instruction per cycle sustained while m_tready is high; stage 1, then the output register.
// The register file is a 2-read 1-write RAM read at accept, written after execute.
// A same-cycle write to a register being read is forwarded into the operand.
// Reset clears per-register valid bits at once; unwritten registers read zero.
// A stalled result holds in the output register while stage 1 still takes one item.
`include "mips_subset_execute_unit_assert.svh"

module mips_subset_execute_unit
    import mseu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instr_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] branch_taken, [16:1] branch_offset,
                                   // [17] print_valid, [49:18] print_value,
                                   // [50] halt, [52:51] fault, [55:53] zero
    output logic [0:0]  m_tuser    // [0] print_kind
);

    logic                  s_accept;
    logic                  advance;
    logic                  in_syscall;
    logic [REG_AW-1:0]     rd_addr_a;
    logic [REG_AW-1:0]     rd_addr_b;
    logic                  hit_a;
    logic                  hit_b;

    logic                  st1_valid_reg, st1_valid_next;
    logic [31:0]           st1_instr_reg;
    logic                  a_byp_reg;
    logic                  b_byp_reg;
    logic [XLEN-1:0]       a_byp_data_reg;
    logic [XLEN-1:0]       b_byp_data_reg;
    logic [REG_COUNT-1:0]  valid_reg, valid_next;

    logic [XLEN-1:0]       ram_a;
    logic [XLEN-1:0]       ram_b;
    logic [XLEN-1:0]       op_a;
    logic [XLEN-1:0]       op_b;

    reg_write_t            wr_req;
    reg_write_t            wr;
    result_t               res;

    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg;

    logic [5:0]            opc;
    logic [5:0]            fn;
    logic [REG_AW-1:0]     rt;
    logic [REG_AW-1:0]     rd;
    logic [15:0]           imm;
    logic [XLEN-1:0]       simm;
    logic [XLEN-1:0]       zimm;
    logic [XLEN-1:0]       prod;

    assign advance  = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_syscall = (s_tdata[31:26] == OP_SPECIAL) && (s_tdata[5:0] == FN_SYSCALL);
    assign rd_addr_a  = in_syscall ? REG_V0 : s_tdata[25:21];
    assign rd_addr_b  = in_syscall ? REG_A0 : s_tdata[20:16];

    assign hit_a = wr.en && (wr.addr == rd_addr_a);
    assign hit_b = wr.en && (wr.addr == rd_addr_b);

    mseu_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .we      (wr.en),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .re      (s_accept),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    assign op_a = a_byp_reg ? a_byp_data_reg : ram_a;
    assign op_b = b_byp_reg ? b_byp_data_reg : ram_b;

    assign opc  = st1_instr_reg[31:26];
    assign fn   = st1_instr_reg[5:0];
    assign rt   = st1_instr_reg[20:16];
    assign rd   = st1_instr_reg[15:11];
    assign imm  = st1_instr_reg[15:0];
    assign simm = {{(XLEN-16){imm[15]}}, imm};
    assign zimm = {{(XLEN-16){1'b0}}, imm};
    assign prod = op_a * op_b;

    always_comb begin
        res         = '0;
        res.fault   = FAULT_NONE;
        wr_req      = '0;
        unique case (opc)
            OP_SPECIAL: begin
                wr_req.addr = rd;
                unique case (fn)
                    FN_ADD: begin
                        wr_req.en   = 1'b1;
                        wr_req.data = op_a + op_b;
                    end
                    FN_SUB: begin
                        wr_req.en   = 1'b1;
                        wr_req.data = op_a - op_b;
                    end
                    FN_AND: begin
                        wr_req.en   = 1'b1;
                        wr_req.data = op_a & op_b;
                    end
                    FN_OR: begin
                        wr_req.en   = 1'b1;
                        wr_req.data = op_a | op_b;
                    end
                    FN_SLT: begin
                        wr_req.en   = 1'b1;
                        wr_req.data = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
                    end
                    FN_SYSCALL: begin
                        // operand a holds v0, operand b holds a0
                        if (op_a == SYS_PRINT_INT) begin
                            res.print_valid = 1'b1;
                            res.print_value = op_b;
                        end else if (op_a == SYS_PRINT_CHAR) begin
                            res.print_valid = 1'b1;
                            res.print_kind  = 1'b1;
                            res.print_value = op_b;
                        end else if (op_a == SYS_EXIT) begin
                            res.halt = 1'b1;
                        end else begin
                            res.fault = FAULT_SYSCALL;
                        end
                    end
                    default: res.fault = FAULT_INSTR;
                endcase
            end
            OP_SPECIAL2: begin
                wr_req.addr = rd;
                if (fn == FN_MUL) begin
                    wr_req.en   = 1'b1;
                    wr_req.data = prod;
                end else begin
                    res.fault = FAULT_INSTR;
                end
            end
            OP_BEQ: begin
                if (op_a == op_b) begin
                    res.branch_taken  = 1'b1;
                    res.branch_offset = imm;
                end
            end
            OP_BNE: begin
                if (op_a != op_b) begin
                    res.branch_taken  = 1'b1;
                    res.branch_offset = imm;
                end
            end
            OP_ADDI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = rt;
                wr_req.data = op_a + simm;
            end
            OP_SLTI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = rt;
                wr_req.data = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(simm))};
            end
            OP_ANDI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = rt;
                wr_req.data = op_a & zimm;
            end
            OP_ORI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = rt;
                wr_req.data = op_a | zimm;
            end
            OP_LUI: begin
                wr_req.en   = 1'b1;
                wr_req.addr = rt;
                wr_req.data = {imm, 16'h0000};
            end
            default: res.fault = FAULT_INSTR;
        endcase
    end

    // $zero is never written, so its valid bit stays low and it reads zero
    always_comb begin
        wr      = wr_req;
        wr.en   = advance && wr_req.en && (wr_req.addr != REG_ZERO);
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr.en) begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_accept) begin
            st1_valid_next = 1'b1;
        end else if (advance) begin
            st1_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_instr_reg  <= s_tdata;
            a_byp_reg      <= hit_a || !valid_reg[rd_addr_a];
            b_byp_reg      <= hit_b || !valid_reg[rd_addr_b];
            a_byp_data_reg <= hit_a ? wr.data : '0;
            b_byp_data_reg <= hit_b ? wr.data : '0;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_res_reg.print_kind;
    assign m_tdata    = {3'b000,
                         out_res_reg.fault,
                         out_res_reg.halt,
                         out_res_reg.print_value,
                         out_res_reg.print_valid,
                         out_res_reg.branch_offset,
                         out_res_reg.branch_taken};

    `MSEU_ASSERT_NOW(a_no_zero_write, aclk, aresetn, wr.en, wr.addr != REG_ZERO,
                     "write to register zero")
    `MSEU_ASSERT_NOW(a_no_overrun, aclk, aresetn, st1_valid_reg && !advance, !s_accept,
                     "stage 1 overwritten while stalled")
    `MSEU_ASSERT_NOW(a_fault_clean, aclk, aresetn, m_tvalid && (m_tdata[52:51] != FAULT_NONE),
                     !m_tdata[17] && !m_tdata[50] && !m_tdata[0], "fault with side outputs")
    `MSEU_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_tvalid,
                      "executed transaction not presented")

endmodule
